// ----- rtl/core/telnet_receive_parser_macros.svh -----
// ----------------------------------------------------------------------------
// Telnet receive parser assertion macros
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TELNET_RECEIVE_PARSER_MACROS_SVH
`define TELNET_RECEIVE_PARSER_MACROS_SVH

// Condition that must hold at every clock edge.
`define TRP_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("telnet receive parser: check failed");

// Consequent that must hold in the same cycle as the antecedent.
`define TRP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("telnet receive parser: implication failed");

// Consequent that must hold in the cycle after the antecedent.
`define TRP_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("telnet receive parser: next-cycle check failed");

`endif

// ----- rtl/core/trp_pkg.sv -----
// ----------------------------------------------------------------------------
// Telnet receive parser package
// Protocol byte codes, result kinds and the result record.
// ----------------------------------------------------------------------------
package trp_pkg;

	// Telnet commands.
	localparam logic [7:0] CMD_IAC  = 8'hFF;
	localparam logic [7:0] CMD_DONT = 8'hFE;
	localparam logic [7:0] CMD_DO   = 8'hFD;
	localparam logic [7:0] CMD_WONT = 8'hFC;
	localparam logic [7:0] CMD_WILL = 8'hFB;
	localparam logic [7:0] CMD_SB   = 8'hFA;
	localparam logic [7:0] CMD_GA   = 8'hF9;
	localparam logic [7:0] CMD_SE   = 8'hF0;

	// Telnet options.
	localparam logic [7:0] OPT_ECHO    = 8'd1;
	localparam logic [7:0] OPT_SGA     = 8'd3;
	localparam logic [7:0] OPT_TTYPE   = 8'd24;
	localparam logic [7:0] OPT_NAWS    = 8'd31;
	localparam logic [7:0] OPT_CHARSET = 8'd42;
	localparam logic [7:0] OPT_GMCP    = 8'd201;

	// Subnegotiation verbs.
	localparam logic [7:0] SUB_SEND    = 8'd1;
	localparam logic [7:0] SUB_REQUEST = 8'd1;

	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic [7:0] CH_CR = 8'd13;

	// Charset token matching: five characters, position six means too long.
	localparam logic [2:0] TOKEN_LEN  = 3'd5;
	localparam logic [2:0] TOKEN_OVER = 3'd6;

	// Configuration register indexes.
	localparam logic [7:0] CFG_WINDOW_WIDTH  = 8'd0;
	localparam logic [7:0] CFG_WINDOW_HEIGHT = 8'd1;

	localparam logic [15:0] WINDOW_WIDTH_RESET  = 16'd80;
	localparam logic [15:0] WINDOW_HEIGHT_RESET = 16'd24;

	typedef enum logic [2:0] {
		KIND_DATA           = 3'd0,
		KIND_LINE_END       = 3'd1,
		KIND_PROMPT_END     = 3'd2,
		KIND_NEGOTIATE      = 3'd3,
		KIND_SEND_TTYPE     = 3'd4,
		KIND_SEND_NAWS      = 3'd5,
		KIND_CHARSET_ACCEPT = 3'd6,
		KIND_CHARSET_REJECT = 3'd7
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
		logic [7:0] command;
		logic       echo_remote;
		logic       last;
	} result_t;

	// Character of the accepted charset name at a token position.
	function automatic logic [7:0] token_char(input logic [2:0] pos, input logic upper);
		logic [7:0] ch;
		case (pos)
			3'd0: ch = upper ? 8'h55 : 8'h75;  // U / u
			3'd1: ch = upper ? 8'h54 : 8'h74;  // T / t
			3'd2: ch = upper ? 8'h46 : 8'h66;  // F / f
			3'd3: ch = 8'h2D;                  // -
			3'd4: ch = 8'h38;                  // 8
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic result_t make_result(input kind_t k, input logic [7:0] v,
	                                        input logic [7:0] c);
		result_t r;
		r.kind        = k;
		r.value       = v;
		r.command     = c;
		r.echo_remote = 1'b0;
		r.last        = 1'b0;
		return r;
	endfunction

endpackage

// ----- rtl/core/telnet_receive_parser.sv -----
// ----------------------------------------------------------------------------
// Telnet receive parser
// Each byte passes the input register, then its results the result queue.
// Throughput: one byte per cycle while each byte gives at most one result and
// the output is not stalled. The input stalls whenever the queued results plus
// those of the byte in the input register exceed two, so a byte with two
// results holds off intake and an output stall fills the queue.
// Reset (arst_n low) returns the parser to plain data and clears all flags.
// ----------------------------------------------------------------------------
`include "telnet_receive_parser_macros.svh"

module telnet_receive_parser (
	input  logic        clk,
	input  logic        arst_n,
	// Received byte channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	// Result channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [7:0]  value,
	output logic [7:0]  command,
	output logic        echo_remote,
	output logic        last,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	typedef enum logic [3:0] {
		ST_DATA   = 4'd0,
		ST_IAC    = 4'd1,
		ST_WILL   = 4'd2,
		ST_WONT   = 4'd3,
		ST_DO     = 4'd4,
		ST_DONT   = 4'd5,
		ST_SB     = 4'd6,
		ST_SBDATA = 4'd7,
		ST_SBIAC  = 4'd8
	} state_t;

	// Input register stage.
	logic       in_accept;
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Parser state.
	state_t     state_q, state_d;
	logic [7:0] sub_opt_q, sub_opt_d;
	logic [1:0] sub_cnt_q, sub_cnt_d;
	logic [7:0] sub_first_q, sub_first_d;
	logic [7:0] delim_q, delim_d;
	logic [2:0] tok_pos_q, tok_pos_d;
	logic [2:0] flags_q, flags_d;
	logic       nonempty_q, nonempty_d;
	logic       held_q, held_d;
	logic       echo_q, echo_d;
	logic       naws_q, naws_d;

	logic [15:0] win_width_q;
	logic [15:0] win_height_q;

	// Work of the current byte.
	logic                do_data, do_sub, do_end;
	logic                charset_active;
	logic                token_done;
	logic                accept_cs;
	logic [1:0]          n_push;
	trp_pkg::result_t    res [2];

	// Result queue.
	trp_pkg::result_t    fifo_q [4];
	logic [1:0]          wr_ptr_q, rd_ptr_q;
	logic [2:0]          cnt_q;
	logic                pop;
	trp_pkg::result_t    head;

	// Terms used by the checks at the end of the module.
	logic                wr_width, wr_height, naws_step;

	// ------------------------------------------------------------------------
	// Handshakes. A byte is taken only if the queue can absorb both the results
	// of the byte now in the input register and a worst-case two results of the new one.
	// ------------------------------------------------------------------------
	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (cnt_q + {1'b0, n_push}) > 3'd2;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= rx_byte;
		end
	end

	// Window-size registers, written through the configuration channel. The parser
	// does not read them and no port brings them out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_width_q  <= trp_pkg::WINDOW_WIDTH_RESET;
			win_height_q <= trp_pkg::WINDOW_HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == trp_pkg::CFG_WINDOW_WIDTH) begin
				win_width_q <= cfg_data;
			end else if (cfg_index == trp_pkg::CFG_WINDOW_HEIGHT) begin
				win_height_q <= cfg_data;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Parser step for the byte in the input register.
	// ------------------------------------------------------------------------
	assign charset_active = (sub_opt_q == trp_pkg::OPT_CHARSET) && (sub_cnt_q != 2'd0) &&
	                        (sub_first_q == trp_pkg::SUB_REQUEST);

	// A token counts as found when exactly five characters matched one spelling.
	assign token_done = (tok_pos_q == trp_pkg::TOKEN_LEN) && (flags_q[1:0] != 2'b00);

	always_comb begin
		state_d     = state_q;
		sub_opt_d   = sub_opt_q;
		sub_cnt_d   = sub_cnt_q;
		sub_first_d = sub_first_q;
		delim_d     = delim_q;
		tok_pos_d   = tok_pos_q;
		flags_d     = flags_q;
		nonempty_d  = nonempty_q;
		held_d      = held_q;
		echo_d      = echo_q;
		naws_d      = naws_q;
		do_data     = 1'b0;
		do_sub      = 1'b0;
		do_end      = 1'b0;
		accept_cs   = 1'b0;
		n_push      = 2'd0;
		res[0]      = trp_pkg::make_result(trp_pkg::KIND_DATA, 8'd0, 8'd0);
		res[1]      = trp_pkg::make_result(trp_pkg::KIND_DATA, 8'd0, 8'd0);

		if (valid_s1) begin
			case (state_q)
				ST_IAC: begin
					state_d = ST_DATA;
					if (byte_s1 == trp_pkg::CMD_IAC) begin
						do_data = 1'b1;
					end else if (byte_s1 == trp_pkg::CMD_WILL) begin
						state_d = ST_WILL;
					end else if (byte_s1 == trp_pkg::CMD_WONT) begin
						state_d = ST_WONT;
					end else if (byte_s1 == trp_pkg::CMD_DO) begin
						state_d = ST_DO;
					end else if (byte_s1 == trp_pkg::CMD_DONT) begin
						state_d = ST_DONT;
					end else if (byte_s1 == trp_pkg::CMD_SB) begin
						state_d = ST_SB;
					end else if (byte_s1 == trp_pkg::CMD_GA) begin
						if (held_q) begin
							held_d = 1'b0;
							res[n_push[0]] = trp_pkg::make_result(trp_pkg::KIND_DATA,
							                                      trp_pkg::CH_CR, 8'd0);
							n_push = n_push + 2'd1;
						end
						if (nonempty_q) begin
							res[n_push[0]] = trp_pkg::make_result(trp_pkg::KIND_PROMPT_END,
							                                      8'd0, 8'd0);
							n_push     = n_push + 2'd1;
							nonempty_d = 1'b0;
						end
					end
				end
				ST_WILL: begin
					state_d = ST_DATA;
					if (byte_s1 == trp_pkg::OPT_ECHO) begin
						echo_d = 1'b1;
						res[0] = trp_pkg::make_result(trp_pkg::KIND_NEGOTIATE, byte_s1,
						                              trp_pkg::CMD_DO);
					end else if (byte_s1 == trp_pkg::OPT_SGA ||
					             byte_s1 == trp_pkg::OPT_GMCP) begin
						res[0] = trp_pkg::make_result(trp_pkg::KIND_NEGOTIATE, byte_s1,
						                              trp_pkg::CMD_DO);
					end else begin
						res[0] = trp_pkg::make_result(trp_pkg::KIND_NEGOTIATE, byte_s1,
						                              trp_pkg::CMD_DONT);
					end
					n_push = 2'd1;
				end
				ST_WONT: begin
					state_d = ST_DATA;
					if (byte_s1 == trp_pkg::OPT_ECHO) begin
						echo_d = 1'b0;
					end
				end
				ST_DO: begin
					state_d = ST_DATA;
					if (byte_s1 == trp_pkg::OPT_NAWS) begin
						naws_d = 1'b1;
						res[0] = trp_pkg::make_result(trp_pkg::KIND_SEND_NAWS, 8'd0, 8'd0);
						n_push = 2'd1;
					end else if (byte_s1 == trp_pkg::OPT_TTYPE) begin
						res[0] = trp_pkg::make_result(trp_pkg::KIND_SEND_TTYPE, 8'd0, 8'd0);
						n_push = 2'd1;
					end else if (byte_s1 != trp_pkg::OPT_CHARSET) begin
						res[0] = trp_pkg::make_result(trp_pkg::KIND_NEGOTIATE, byte_s1,
						                              trp_pkg::CMD_WONT);
						n_push = 2'd1;
					end
				end
				ST_DONT: begin
					state_d = ST_DATA;
					if (byte_s1 == trp_pkg::OPT_NAWS) begin
						naws_d = 1'b0;
					end
				end
				ST_SB: begin
					state_d     = ST_SBDATA;
					sub_opt_d   = byte_s1;
					sub_cnt_d   = 2'd0;
					sub_first_d = 8'd0;
					delim_d     = 8'd0;
					tok_pos_d   = 3'd0;
					flags_d     = 3'b000;
				end
				ST_SBDATA: begin
					if (byte_s1 == trp_pkg::CMD_IAC) begin
						state_d = ST_SBIAC;
					end else begin
						do_sub = 1'b1;
					end
				end
				ST_SBIAC: begin
					if (byte_s1 == trp_pkg::CMD_SE) begin
						do_end  = 1'b1;
						state_d = ST_DATA;
					end else if (byte_s1 == trp_pkg::CMD_IAC) begin
						// Escaped 0xFF inside the subnegotiation; the byte itself is 0xFF.
						do_sub  = 1'b1;
						state_d = ST_SBDATA;
					end else begin
						state_d = ST_DATA;
					end
				end
				default: begin
					if (byte_s1 == trp_pkg::CMD_IAC) begin
						state_d = ST_IAC;
					end else begin
						state_d = ST_DATA;
						do_data = 1'b1;
					end
				end
			endcase

			// Data byte: a held CR is released unless this byte is LF.
			if (do_data) begin
				if (held_q) begin
					held_d = 1'b0;
					if (byte_s1 == trp_pkg::CH_LF) begin
						res[n_push[0]] = trp_pkg::make_result(trp_pkg::KIND_LINE_END,
						                                      8'd0, 8'd0);
						n_push     = n_push + 2'd1;
						nonempty_d = 1'b0;
					end else begin
						res[n_push[0]] = trp_pkg::make_result(trp_pkg::KIND_DATA,
						                                      trp_pkg::CH_CR, 8'd0);
						n_push = n_push + 2'd1;
					end
				end
				if (!(held_q && byte_s1 == trp_pkg::CH_LF)) begin
					if (byte_s1 == trp_pkg::CH_CR) begin
						held_d     = 1'b1;
						nonempty_d = 1'b1;
					end else if (byte_s1 == trp_pkg::CH_LF) begin
						res[n_push[0]] = trp_pkg::make_result(trp_pkg::KIND_LINE_END,
						                                      8'd0, 8'd0);
						n_push     = n_push + 2'd1;
						nonempty_d = 1'b0;
					end else begin
						res[n_push[0]] = trp_pkg::make_result(trp_pkg::KIND_DATA,
						                                      byte_s1, 8'd0);
						n_push     = n_push + 2'd1;
						nonempty_d = 1'b1;
					end
				end
			end

			// Subnegotiation payload byte: verb, then delimiter, then tokens.
			if (do_sub) begin
				case (sub_cnt_q)
					2'd0: begin
						sub_first_d = byte_s1;
						sub_cnt_d   = 2'd1;
					end
					2'd1: begin
						delim_d   = byte_s1;
						sub_cnt_d = 2'd2;
						tok_pos_d = 3'd0;
						flags_d   = 3'b011;
					end
					default: begin
						if (charset_active) begin
							if (byte_s1 == delim_q) begin
								flags_d   = {flags_q[2] | token_done, 2'b11};
								tok_pos_d = 3'd0;
							end else if (tok_pos_q < trp_pkg::TOKEN_LEN) begin
								flags_d[0] = flags_q[0] &&
								             (byte_s1 == trp_pkg::token_char(tok_pos_q, 1'b1));
								flags_d[1] = flags_q[1] &&
								             (byte_s1 == trp_pkg::token_char(tok_pos_q, 1'b0));
								tok_pos_d  = tok_pos_q + 3'd1;
							end else begin
								flags_d   = {flags_q[2], 2'b00};
								tok_pos_d = trp_pkg::TOKEN_OVER;
							end
						end
					end
				endcase
			end

			// End of subnegotiation: answer terminal-type SEND or charset REQUEST.
			if (do_end) begin
				if (sub_opt_q == trp_pkg::OPT_TTYPE && sub_cnt_q != 2'd0 &&
				    sub_first_q == trp_pkg::SUB_SEND) begin
					res[0] = trp_pkg::make_result(trp_pkg::KIND_SEND_TTYPE, 8'd0, 8'd0);
					n_push = 2'd1;
				end else if (charset_active) begin
					accept_cs  = flags_q[2] | ((sub_cnt_q == 2'd2) && token_done);
					flags_d[2] = accept_cs;
					res[0] = trp_pkg::make_result(accept_cs ? trp_pkg::KIND_CHARSET_ACCEPT
					                                        : trp_pkg::KIND_CHARSET_REJECT,
					                              8'd0, 8'd0);
					n_push = 2'd1;
				end
			end
		end

		// The echo flag reported is the one after this byte; the final result
		// of the byte is marked.
		res[0].echo_remote = echo_d;
		res[1].echo_remote = echo_d;
		res[0].last        = (n_push == 2'd1);
		res[1].last        = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_DATA;
			sub_opt_q   <= 8'd0;
			sub_cnt_q   <= 2'd0;
			sub_first_q <= 8'd0;
			delim_q     <= 8'd0;
			tok_pos_q   <= 3'd0;
			flags_q     <= 3'b000;
			nonempty_q  <= 1'b0;
			held_q      <= 1'b0;
			echo_q      <= 1'b0;
			naws_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			sub_opt_q   <= sub_opt_d;
			sub_cnt_q   <= sub_cnt_d;
			sub_first_q <= sub_first_d;
			delim_q     <= delim_d;
			tok_pos_q   <= tok_pos_d;
			flags_q     <= flags_d;
			nonempty_q  <= nonempty_d;
			held_q      <= held_d;
			echo_q      <= echo_d;
			naws_q      <= naws_d;
		end
	end

	// ------------------------------------------------------------------------
	// Result queue: up to two writes per cycle, one read per output transfer.
	// ------------------------------------------------------------------------
	assign out_valid = (cnt_q != 3'd0);
	assign pop       = out_valid && !out_stall;
	assign head      = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			fifo_q[wr_ptr_q] <= res[0];
		end
		if (n_push == 2'd2) begin
			fifo_q[wr_ptr_q + 2'd1] <= res[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			cnt_q    <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			cnt_q    <= cnt_q + {1'b0, n_push} - {2'b00, pop};
		end
	end

	assign kind        = head.kind;
	assign value       = head.value;
	assign command     = head.command;
	assign echo_remote = head.echo_remote;
	assign last        = head.last;

	// ------------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------------
	assign wr_width  = cfg_valid && cfg_ready && (cfg_index == trp_pkg::CFG_WINDOW_WIDTH);
	assign wr_height = cfg_valid && cfg_ready && (cfg_index == trp_pkg::CFG_WINDOW_HEIGHT);
	assign naws_step = valid_s1 && (state_q == ST_DO) && (byte_s1 == trp_pkg::OPT_NAWS);

	`TRP_ASSERT_NXT(a_room_after_accept, in_accept, cnt_q <= 3'd2)
	`TRP_ASSERT_IMP(a_held_cr_nonempty, held_q, nonempty_q)
	`TRP_ASSERT_IMP(a_pair_complete, out_valid && !last, cnt_q >= 3'd2)
	`TRP_ASSERT_NXT(a_naws_agreed, naws_step, naws_q)
	`TRP_ASSERT_NXT(a_cfg_width, wr_width, win_width_q == $past(cfg_data))
	`TRP_ASSERT_NXT(a_cfg_height, wr_height, win_height_q == $past(cfg_data))

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Telnet receive parser testbench
// Sends received byte streams through the parser and checks every result
// against a cycle-free prediction of the parse. Directed streams cover the
// carriage-return, prompt and subnegotiation corner cases. Random traffic is
// built mostly from well-formed commands and subnegotiations. It runs with
// and without idle cycles on both channels, and the window registers are
// rewritten between phases.
// ----------------------------------------------------------------------------
module tb;

	// Cycles without any transfer allowed before the run is declared hung.
	localparam int QUIET_LIMIT  = 2000;
	// Cycles the result side is held off during the backpressure test.
	localparam int HOLD_CYCLES  = 300;
	// Settling time after the last result.
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_BYTES  = 170;

	// Charset names that a request token may match, first character on top.
	localparam logic [39:0] CHARSET_UPPER = "UTF-8";
	localparam logic [39:0] CHARSET_LOWER = "utf-8";

	// Parser states as the prediction tracks them.
	typedef enum logic [3:0] {
		PS_DATA, PS_IAC, PS_WILL, PS_WONT, PS_DO, PS_DONT, PS_SB, PS_SBDATA, PS_SBIAC
	} parse_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  kind;
	logic [7:0]  value;
	logic [7:0]  command;
	logic        echo_remote;
	logic        last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [15:0] cfg_data;

	telnet_receive_parser u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.value       (value),
		.command     (command),
		.echo_remote (echo_remote),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Predicted parser state. It mirrors the block's state and is advanced
	// once per accepted byte transfer.
	// ------------------------------------------------------------------------
	parse_t      pstate;
	logic [7:0]  sn_option;
	logic [1:0]  sn_count;
	logic [7:0]  sn_first;
	logic [7:0]  cs_delim;
	logic [2:0]  tok_pos;
	logic [2:0]  tok_match;  // bit 0 upper name, bit 1 lower name, bit 2 found
	logic        line_nonempty;
	logic        held_cr;
	logic        remote_echo;
	logic        size_agreed;
	logic [15:0] window_cols;
	logic [15:0] window_rows;

	// Results of the byte being predicted, and the results still to arrive.
	trp_pkg::result_t step_buf [2];
	int               step_n;
	trp_pkg::result_t pending_results [$];

	// Run bookkeeping.
	int          error_count;
	int          bytes_sent;
	int          results_checked;
	int          cfg_writes;
	int          kinds_seen [8];
	int          quiet_cycles;
	int          send_idle_pct;
	int          stall_pct;
	logic        hold_req = 1'b0;
	int          hold_left;
	trp_pkg::result_t want;

	function automatic void emit(trp_pkg::kind_t k, logic [7:0] v, logic [7:0] c);
		if (step_n < 2) begin
			step_buf[step_n].kind        = k;
			step_buf[step_n].value       = v;
			step_buf[step_n].command     = c;
			step_buf[step_n].echo_remote = 1'b0;
			step_buf[step_n].last        = 1'b0;
			step_n++;
		end
	endfunction

	// A data byte. A held CR is released as data unless this byte is LF, in
	// which case the pair collapses into one line end.
	function automatic void data_char(logic [7:0] c);
		if (held_cr) begin
			held_cr = 1'b0;
			if (c == trp_pkg::CH_LF) begin
				emit(trp_pkg::KIND_LINE_END, 8'd0, 8'd0);
				line_nonempty = 1'b0;
				return;
			end
			emit(trp_pkg::KIND_DATA, trp_pkg::CH_CR, 8'd0);
		end
		if (c == trp_pkg::CH_CR) begin
			held_cr = 1'b1;
			line_nonempty = 1'b1;
		end else if (c == trp_pkg::CH_LF) begin
			emit(trp_pkg::KIND_LINE_END, 8'd0, 8'd0);
			line_nonempty = 1'b0;
		end else begin
			emit(trp_pkg::KIND_DATA, c, 8'd0);
			line_nonempty = 1'b1;
		end
	endfunction

	function automatic bit charset_requested();
		return sn_option == trp_pkg::OPT_CHARSET && sn_count >= 2'd1 &&
		       sn_first == trp_pkg::SUB_REQUEST;
	endfunction

	// A token counts as found only if all five characters matched one of
	// the two spellings and nothing followed them.
	function automatic void close_token();
		if (tok_pos == trp_pkg::TOKEN_LEN && tok_match[1:0] != 2'b00)
			tok_match[2] = 1'b1;
	endfunction

	function automatic void sub_char(logic [7:0] c);
		if (sn_count == 2'd0) begin
			sn_first = c;
			sn_count = 2'd1;
			return;
		end
		if (sn_count == 2'd1) begin
			cs_delim  = c;
			sn_count  = 2'd2;
			tok_pos   = 3'd0;
			tok_match = 3'b011;
			return;
		end
		if (!charset_requested())
			return;
		if (c == cs_delim) begin
			close_token();
			tok_pos   = 3'd0;
			tok_match = {tok_match[2], 2'b11};
			return;
		end
		if (tok_pos < trp_pkg::TOKEN_LEN) begin
			if (c != CHARSET_UPPER[39 - 8 * int'(tok_pos) -: 8])
				tok_match[0] = 1'b0;
			if (c != CHARSET_LOWER[39 - 8 * int'(tok_pos) -: 8])
				tok_match[1] = 1'b0;
			tok_pos++;
		end else begin
			tok_match[1:0] = 2'b00;
			tok_pos = trp_pkg::TOKEN_OVER;
		end
	endfunction

	function automatic void sub_close();
		if (sn_option == trp_pkg::OPT_TTYPE && sn_count >= 2'd1 &&
		    sn_first == trp_pkg::SUB_SEND) begin
			emit(trp_pkg::KIND_SEND_TTYPE, 8'd0, 8'd0);
		end else if (charset_requested()) begin
			if (sn_count >= 2'd2)
				close_token();
			emit(tok_match[2] ? trp_pkg::KIND_CHARSET_ACCEPT : trp_pkg::KIND_CHARSET_REJECT,
			     8'd0, 8'd0);
		end
	endfunction

	function automatic void reset_parse_state();
		pstate        = PS_DATA;
		sn_option     = 8'd0;
		sn_count      = 2'd0;
		sn_first      = 8'd0;
		cs_delim      = 8'd0;
		tok_pos       = 3'd0;
		tok_match     = 3'd0;
		line_nonempty = 1'b0;
		held_cr       = 1'b0;
		remote_echo   = 1'b0;
		size_agreed   = 1'b0;
		window_cols   = trp_pkg::WINDOW_WIDTH_RESET;
		window_rows   = trp_pkg::WINDOW_HEIGHT_RESET;
	endfunction

	// Advances the predicted parser by one byte and queues what it emits.
	function automatic void parse_byte_results(logic [7:0] c);
		int k;
		step_n = 0;
		case (pstate)
			PS_IAC: begin
				pstate = PS_DATA;
				case (c)
					trp_pkg::CMD_IAC:  data_char(c);
					trp_pkg::CMD_WILL: pstate = PS_WILL;
					trp_pkg::CMD_WONT: pstate = PS_WONT;
					trp_pkg::CMD_DO:   pstate = PS_DO;
					trp_pkg::CMD_DONT: pstate = PS_DONT;
					trp_pkg::CMD_SB:   pstate = PS_SB;
					trp_pkg::CMD_GA: begin
						if (held_cr) begin
							held_cr = 1'b0;
							emit(trp_pkg::KIND_DATA, trp_pkg::CH_CR, 8'd0);
						end
						if (line_nonempty) begin
							emit(trp_pkg::KIND_PROMPT_END, 8'd0, 8'd0);
							line_nonempty = 1'b0;
						end
					end
					default: ;
				endcase
			end
			PS_WILL: begin
				if (c == trp_pkg::OPT_ECHO) begin
					remote_echo = 1'b1;
					emit(trp_pkg::KIND_NEGOTIATE, c, trp_pkg::CMD_DO);
				end else if (c == trp_pkg::OPT_SGA || c == trp_pkg::OPT_GMCP) begin
					emit(trp_pkg::KIND_NEGOTIATE, c, trp_pkg::CMD_DO);
				end else begin
					emit(trp_pkg::KIND_NEGOTIATE, c, trp_pkg::CMD_DONT);
				end
				pstate = PS_DATA;
			end
			PS_WONT: begin
				if (c == trp_pkg::OPT_ECHO)
					remote_echo = 1'b0;
				pstate = PS_DATA;
			end
			PS_DO: begin
				if (c == trp_pkg::OPT_NAWS) begin
					size_agreed = 1'b1;
					emit(trp_pkg::KIND_SEND_NAWS, 8'd0, 8'd0);
				end else if (c == trp_pkg::OPT_TTYPE) begin
					emit(trp_pkg::KIND_SEND_TTYPE, 8'd0, 8'd0);
				end else if (c != trp_pkg::OPT_CHARSET) begin
					emit(trp_pkg::KIND_NEGOTIATE, c, trp_pkg::CMD_WONT);
				end
				pstate = PS_DATA;
			end
			PS_DONT: begin
				if (c == trp_pkg::OPT_NAWS)
					size_agreed = 1'b0;
				pstate = PS_DATA;
			end
			PS_SB: begin
				sn_option = c;
				sn_count  = 2'd0;
				sn_first  = 8'd0;
				cs_delim  = 8'd0;
				tok_pos   = 3'd0;
				tok_match = 3'd0;
				pstate    = PS_SBDATA;
			end
			PS_SBDATA: begin
				if (c == trp_pkg::CMD_IAC)
					pstate = PS_SBIAC;
				else
					sub_char(c);
			end
			PS_SBIAC: begin
				if (c == trp_pkg::CMD_SE) begin
					sub_close();
					pstate = PS_DATA;
				end else if (c == trp_pkg::CMD_IAC) begin
					sub_char(trp_pkg::CMD_IAC);
					pstate = PS_SBDATA;
				end else begin
					pstate = PS_DATA;
				end
			end
			default: begin
				if (c == trp_pkg::CMD_IAC)
					pstate = PS_IAC;
				else
					data_char(c);
			end
		endcase
		// The echo flag reported is the one in force after the byte.
		for (k = 0; k < step_n; k++) begin
			step_buf[k].echo_remote = remote_echo;
			step_buf[k].last        = (k == step_n - 1);
			pending_results = {pending_results, step_buf[k]};
		end
	endfunction

	// ------------------------------------------------------------------------
	// Result checking. Every result transfer is matched against the oldest
	// queued prediction, field by field.
	// ------------------------------------------------------------------------
	function automatic void check_field(string name, logic [7:0] got, logic [7:0] exp_v);
		if (got !== exp_v) begin
			error_count++;
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t ns: unexpected result, expected none, got kind %0d value %0d",
				         $time, kind, value);
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				results_checked++;
				kinds_seen[want.kind]++;
				check_field("kind", {5'd0, kind}, {5'd0, want.kind});
				check_field("value", value, want.value);
				check_field("command", command, want.command);
				check_field("echo_remote", {7'd0, echo_remote}, {7'd0, want.echo_remote});
				check_field("last", {7'd0, last}, {7'd0, want.last});
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result-side stall. A hold-off request keeps the output stalled for a
	// long stretch; otherwise the stall is drawn at random each cycle.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req  <= 1'b0;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
		end
	end

	// Watchdog: the run is hung if no transfer of any kind happens for
	// QUIET_LIMIT consecutive cycles.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
			         $time, QUIET_LIMIT, pending_results.size());
			$display("status: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------------

	// Offers one byte, with random idle cycles ahead of it, and predicts its
	// results once the transfer is accepted. Valid stays high after the
	// transfer so back-to-back bytes need no extra assignment.
	task automatic send_byte(input logic [7:0] b);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall);
		parse_byte_results(b);
		bytes_sent++;
	endtask

	task automatic send_command(input logic [7:0] cmd, input logic [7:0] arg);
		send_byte(trp_pkg::CMD_IAC);
		send_byte(cmd);
		send_byte(arg);
	endtask

	// A byte inside a subnegotiation; a literal 0xFF has to be doubled.
	task automatic send_sub(input logic [7:0] b);
		if (b == trp_pkg::CMD_IAC)
			send_byte(trp_pkg::CMD_IAC);
		send_byte(b);
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_sub(s[i]);
	endtask

	task automatic sub_begin(input logic [7:0] opt);
		send_byte(trp_pkg::CMD_IAC);
		send_byte(trp_pkg::CMD_SB);
		send_byte(opt);
	endtask

	task automatic sub_end();
		send_byte(trp_pkg::CMD_IAC);
		send_byte(trp_pkg::CMD_SE);
	endtask

	// Lowers valid and waits until every predicted result has been checked,
	// then lets the pipeline settle for bytes that produce nothing.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes both window registers back to back; only called while idle.
	task automatic write_window(input logic [15:0] cols, input logic [15:0] rows);
		cfg_valid <= 1'b1;
		cfg_index <= trp_pkg::CFG_WINDOW_WIDTH;
		cfg_data  <= cols;
		do @(posedge clk); while (!cfg_ready);
		window_cols = cols;
		cfg_index <= trp_pkg::CFG_WINDOW_HEIGHT;
		cfg_data  <= rows;
		do @(posedge clk); while (!cfg_ready);
		window_rows = rows;
		cfg_valid <= 1'b0;
		cfg_writes += 2;
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		stall_pct     = recv_pct;
	endtask

	// ------------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------------

	// Plain data handling: byte extremes, escaped 0xFF and the CR rules.
	task automatic test_data_path();
		send_byte(8'h00);
		send_byte(trp_pkg::CMD_IAC);   // IAC IAC is a literal 0xFF
		send_byte(trp_pkg::CMD_IAC);
		send_byte(trp_pkg::CH_CR);     // CR followed by ordinary data
		send_byte("A");
		send_byte(trp_pkg::CH_CR);     // CR CR LF: first CR out, second one folds
		send_byte(trp_pkg::CH_CR);
		send_byte(trp_pkg::CH_LF);
		send_byte(trp_pkg::CMD_IAC);   // GA on an empty line gives nothing
		send_byte(trp_pkg::CMD_GA);
	endtask

	// Negotiation replies and the echo flag, with a CR held across them.
	task automatic test_negotiation();
		send_byte(trp_pkg::CH_CR);
		send_command(trp_pkg::CMD_WILL, trp_pkg::OPT_ECHO);  // CR stays held through this
		send_byte(trp_pkg::CMD_IAC);                         // GA releases the CR, then prompt end
		send_byte(trp_pkg::CMD_GA);
		send_byte(trp_pkg::CMD_IAC);                         // unknown command is dropped
		send_byte(8'h00);
		send_command(trp_pkg::CMD_DO, trp_pkg::OPT_NAWS);
		send_command(trp_pkg::CMD_WONT, trp_pkg::OPT_ECHO);
	endtask

	// A charset request with no delimiter must be rejected.
	task automatic test_subnegotiation();
		sub_begin(trp_pkg::OPT_CHARSET);
		send_byte(trp_pkg::SUB_REQUEST);
		sub_end();
	endtask

	// One charset request with a random delimiter and token list.
	task automatic send_charset_request();
		logic [7:0] delim;
		int         n_tok;
		int         i;
		int         j;
		sub_begin(trp_pkg::OPT_CHARSET);
		if ($urandom_range(9) != 0) begin
			send_sub(($urandom_range(7) == 0) ? 8'($urandom_range(255))
			                                  : trp_pkg::SUB_REQUEST);
			if ($urandom_range(9) != 0) begin
				case ($urandom_range(3))
					0: delim = ";";
					1: delim = " ";
					2: delim = ",";
					default: delim = 8'($urandom_range(255));
				endcase
				send_sub(delim);
				n_tok = $urandom_range(3);
				for (i = 0; i < n_tok; i++) begin
					if (i != 0)
						send_sub(delim);
					case ($urandom_range(6))
						0: send_text("UTF-8");
						1: send_text("utf-8");
						2: send_text("UTF-8X");      // too long to match
						3: send_text("uTf-8");       // mixed case matches neither
						4: send_text("UTF");
						5: send_text("ISO-8859-1");
						default: begin
							for (j = 0; j < $urandom_range(1, 7); j++)
								send_sub(8'($urandom_range(255)));
						end
					endcase
				end
			end
		end
		sub_end();
	endtask

	// Random traffic built mostly from well-formed fragments with random
	// content, with some broken subnegotiations and raw noise mixed in.
	task automatic random_traffic(input int n_bytes);
		int         first_byte;
		int         pick;
		int         n;
		int         i;
		logic [7:0] b;
		logic [7:0] opt;
		first_byte = bytes_sent;
		while (bytes_sent - first_byte < n_bytes) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				n = $urandom_range(1, 8);
				for (i = 0; i < n; i++) begin
					case ($urandom_range(9))
						0, 1: send_byte(trp_pkg::CH_CR);
						2:    send_byte(trp_pkg::CH_LF);
						default: send_byte(8'($urandom_range(254)));
					endcase
				end
			end else if (pick < 36) begin
				send_byte(trp_pkg::CMD_IAC);
				send_byte(trp_pkg::CMD_IAC);
			end else if (pick < 43) begin
				send_byte(trp_pkg::CMD_IAC);
				send_byte(trp_pkg::CMD_GA);
			end else if (pick < 63) begin
				case ($urandom_range(7))
					0: opt = trp_pkg::OPT_ECHO;
					1: opt = trp_pkg::OPT_SGA;
					2: opt = trp_pkg::OPT_TTYPE;
					3: opt = trp_pkg::OPT_NAWS;
					4: opt = trp_pkg::OPT_CHARSET;
					5: opt = trp_pkg::OPT_GMCP;
					default: opt = 8'($urandom_range(255));
				endcase
				case ($urandom_range(3))
					0: send_command(trp_pkg::CMD_WILL, opt);
					1: send_command(trp_pkg::CMD_WONT, opt);
					2: send_command(trp_pkg::CMD_DO, opt);
					default: send_command(trp_pkg::CMD_DONT, opt);
				endcase
			end else if (pick < 70) begin
				// Terminal-type request, sometimes with an odd verb or trailer.
				sub_begin(trp_pkg::OPT_TTYPE);
				n = $urandom_range(0, 3);
				for (i = 0; i < n; i++)
					send_sub((i == 0 && $urandom_range(3) != 0) ? trp_pkg::SUB_SEND
					                                            : 8'($urandom_range(255)));
				sub_end();
			end else if (pick < 84) begin
				send_charset_request();
			end else if (pick < 89) begin
				sub_begin(8'($urandom_range(255)));
				n = $urandom_range(0, 4);
				for (i = 0; i < n; i++)
					send_sub(8'($urandom_range(255)));
				sub_end();
			end else if (pick < 93) begin
				// Subnegotiation cut off by IAC and something other than SE.
				sub_begin(($urandom_range(1) == 0) ? trp_pkg::OPT_CHARSET : trp_pkg::OPT_TTYPE);
				n = $urandom_range(0, 3);
				for (i = 0; i < n; i++)
					send_sub(($urandom_range(1) == 0) ? trp_pkg::SUB_REQUEST
					                                  : 8'($urandom_range(255)));
				b = 8'($urandom_range(253));
				if (b >= trp_pkg::CMD_SE)
					b++;
				send_byte(trp_pkg::CMD_IAC);
				send_byte(b);
			end else if (pick < 96) begin
				send_byte(trp_pkg::CMD_IAC);
				send_byte(8'($urandom_range(248)));
			end else begin
				n = $urandom_range(1, 4);
				for (i = 0; i < n; i++)
					send_byte(8'($urandom_range(255)));
			end
		end
	endtask

	// Holds the result side off for a long stretch while bytes keep coming,
	// so the result queue fills and the input is stalled.
	task automatic test_output_holdoff();
		int i;
		hold_req <= 1'b1;
		for (i = 0; i < 40; i++)
			send_byte(($urandom_range(4) == 0) ? trp_pkg::CH_LF : 8'($urandom_range(32, 126)));
	endtask

	// Traffic with a pause in the middle in which the sender waits for every
	// outstanding result before going on.
	task automatic test_pause_and_resume();
		random_traffic(PHASE_BYTES / 2);
		wait_drained();
		random_traffic(PHASE_BYTES / 2);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		rx_byte   <= 8'd0;
		cfg_valid <= 1'b0;
		cfg_index <= trp_pkg::CFG_WINDOW_WIDTH;
		cfg_data  <= 16'd0;
		reset_parse_state();
		set_idling(0, 0);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_window(16'd0, 16'd0);
		test_data_path();
		test_negotiation();
		test_subnegotiation();

		// Random phases, each under its own idling and window setting.
		wait_drained();
		write_window(16'hFFFF, 16'h0000);
		random_traffic(PHASE_BYTES);

		wait_drained();
		write_window(16'h0000, 16'hFFFF);
		set_idling(83, 0);
		random_traffic(PHASE_BYTES);

		wait_drained();
		write_window(16'($urandom_range(65535)), 16'($urandom_range(65535)));
		set_idling(0, 83);
		random_traffic(PHASE_BYTES);

		set_idling(0, 0);
		test_output_holdoff();

		wait_drained();
		write_window(16'hFFFF, 16'hFFFF);
		set_idling(37, 37);
		test_pause_and_resume();

		wait_drained();
		$display("run covered %0d bytes, %0d results and %0d register writes",
		         bytes_sent, results_checked, cfg_writes);
		$display("kinds: data %0d line %0d prompt %0d nego %0d ttype %0d naws %0d ok %0d rej %0d",
		         kinds_seen[0], kinds_seen[1], kinds_seen[2], kinds_seen[3],
		         kinds_seen[4], kinds_seen[5], kinds_seen[6], kinds_seen[7]);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/trp_pkg.sv
rtl/core/telnet_receive_parser.sv
dv/tb.sv
